/* rtl/point_sector_stride_filter_core_macros.svh */
// ----------------------------------------------------------------------------
// Sector filter assertion macros
// Shared same-cycle and next-cycle implication assertion forms on clk / rst.
// ----------------------------------------------------------------------------
`ifndef POINT_SECTOR_STRIDE_FILTER_CORE_MACROS_SVH
`define POINT_SECTOR_STRIDE_FILTER_CORE_MACROS_SVH

// same-cycle implication
`define PSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the following cycle
`define PSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/psf_pkg.sv */
// ----------------------------------------------------------------------------
// Sector filter package
// Widths, reset values, register map, pipeline types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package psf_pkg;

  localparam int COORD_BITS   = 32;
  localparam int CORDIC_STEPS = 16;

  // internal CORDIC word: coordinates scaled up to sit just below 2^61
  localparam int CW       = 64;
  localparam int SCALE_SH = 62 - COORD_BITS;
  localparam int ZW       = 18;
  localparam int SW       = $clog2(CORDIC_STEPS);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int ANG_W  = 17;

  localparam logic [7:0]              STRIDE_RST    = 8'd2;
  localparam logic                    SECTOR_ON_RST = 1'b1;
  localparam logic signed [ANG_W-1:0] ANGLE_MIN_RST = -17'sd10923;
  localparam logic signed [ANG_W-1:0] ANGLE_MAX_RST = 17'sd10923;

  // quarter turn in pi/32768 units
  localparam logic signed [ZW-1:0] QUARTER = 18'sd16384;

  typedef enum logic [1:0] {
    REG_STRIDE,
    REG_SECTOR_ON,
    REG_ANGLE_MIN,
    REG_ANGLE_MAX
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]              stride;
    logic                    sector_on;
    logic signed [ANG_W-1:0] angle_min;
    logic signed [ANG_W-1:0] angle_max;
  } cfg_t;

  // what travels alongside the bearing computation
  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
    logic                         pass;    // stride and finiteness passed
    logic                         origin;
    logic                         first;
    logic                         last;
  } tag_t;

  typedef struct packed {
    logic                 valid;
    tag_t                 tag;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } stage_t;

  // atan(2^-i) in pi/32768 units, rounded
  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    r = '0;
    case (i)
      5'd0:  r = 18'sd8192;
      5'd1:  r = 18'sd4836;
      5'd2:  r = 18'sd2555;
      5'd3:  r = 18'sd1297;
      5'd4:  r = 18'sd651;
      5'd5:  r = 18'sd326;
      5'd6:  r = 18'sd163;
      5'd7:  r = 18'sd81;
      5'd8:  r = 18'sd41;
      5'd9:  r = 18'sd20;
      5'd10: r = 18'sd10;
      5'd11: r = 18'sd5;
      5'd12: r = 18'sd3;
      5'd13: r = 18'sd1;
      5'd14: r = 18'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/psf_ifs.sv */
// ----------------------------------------------------------------------------
// Sector filter channels
// Point input channel and filter result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface psf_pt_if import psf_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] pz;
  logic                         not_finite;
  logic                         cloud_first;
  logic                         cloud_last;

  modport source (output valid, px, py, pz, not_finite, cloud_first, cloud_last,
                  input ready);
  modport sink   (input valid, px, py, pz, not_finite, cloud_first, cloud_last,
                  output ready);
endinterface

interface psf_res_if import psf_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         keep;
  logic signed [COORD_BITS-1:0] qx;
  logic signed [COORD_BITS-1:0] qy;
  logic signed [COORD_BITS-1:0] qz;
  logic                         end_of_cloud;
  logic                         cloud_empty;

  modport source (output valid, keep, qx, qy, qz, end_of_cloud, cloud_empty,
                  input ready);
  modport sink   (input valid, keep, qx, qy, qz, end_of_cloud, cloud_empty,
                  output ready);
endinterface

/* rtl/psf_cfg.sv */
// ----------------------------------------------------------------------------
// Sector filter configuration registers
// APB-style register file: stride, sector enable and the bearing window.
// ----------------------------------------------------------------------------
module psf_cfg import psf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  cfg_t     regs;
  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr  = psel && penable && pwrite;
  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.stride    <= STRIDE_RST;
      regs.sector_on <= SECTOR_ON_RST;
      regs.angle_min <= ANGLE_MIN_RST;
      regs.angle_max <= ANGLE_MAX_RST;
    end else if (wr) begin
      case (idx)
        REG_STRIDE:    regs.stride    <= pwdata[7:0];
        REG_SECTOR_ON: regs.sector_on <= pwdata[0];
        REG_ANGLE_MIN: regs.angle_min <= pwdata[ANG_W-1:0];
        REG_ANGLE_MAX: regs.angle_max <= pwdata[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_STRIDE:    prdata = DATA_W'(regs.stride);
      REG_SECTOR_ON: prdata = DATA_W'(regs.sector_on);
      REG_ANGLE_MIN: prdata = DATA_W'(regs.angle_min);
      REG_ANGLE_MAX: prdata = DATA_W'(regs.angle_max);
      default:       prdata = '0;
    endcase
  end

endmodule

/* rtl/psf_entry.sv */
// ----------------------------------------------------------------------------
// Sector filter entry cell
// Stride phase tracking, finiteness check and quadrant pre-rotation.
// ----------------------------------------------------------------------------
module psf_entry import psf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [7:0]  stride,
  psf_pt_if.sink      pt,
  output stage_t      st
);

  logic [7:0]           phase;
  logic [7:0]           phase_next;
  logic [7:0]           ph;
  logic [7:0]           eff;
  logic [8:0]           nxt;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] y0;
  logic signed [ZW-1:0] z0;

  assign pt.ready = en;

  always_comb begin
    ph  = pt.cloud_first ? 8'd0 : phase;
    eff = (stride == 8'd0) ? 8'd1 : stride;
    nxt = {1'b0, ph} + 9'd1;
    // a phase left above a newly lowered stride wraps here as well
    phase_next = (pt.cloud_last || nxt >= {1'b0, eff}) ? 8'd0 : nxt[7:0];
  end

  // rotate the left half plane by a quarter turn before the CORDIC steps
  always_comb begin
    xs = CW'(pt.px) <<< SCALE_SH;
    ys = CW'(pt.py) <<< SCALE_SH;
    x0 = xs;
    y0 = ys;
    z0 = '0;
    if (xs[CW-1]) begin
      if (!ys[CW-1]) begin
        x0 = ys;
        y0 = -xs;
        z0 = QUARTER;
      end else begin
        x0 = -ys;
        y0 = xs;
        z0 = -QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= '0;
      st.valid <= 1'b0;
    end else if (en) begin
      st.valid <= pt.valid;
      if (pt.valid) begin
        phase         <= phase_next;
        st.tag.px     <= pt.px;
        st.tag.py     <= pt.py;
        st.tag.pz     <= pt.pz;
        st.tag.pass   <= (ph == 8'd0) && !pt.not_finite;
        st.tag.origin <= (pt.px == '0) && (pt.py == '0);
        st.tag.first  <= pt.cloud_first;
        st.tag.last   <= pt.cloud_last;
        st.x          <= x0;
        st.y          <= y0;
        st.z          <= z0;
      end
    end
  end

endmodule

/* rtl/psf_cordic_cell.sv */
// ----------------------------------------------------------------------------
// Sector filter CORDIC cell
// One vectoring micro-rotation; hands the item on to the next cell.
// ----------------------------------------------------------------------------
module psf_cordic_cell import psf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [SW-1:0] step,
  input  stage_t        d,
  output stage_t        q
);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] da;
  logic signed [CW-1:0] x_next;
  logic signed [CW-1:0] y_next;
  logic signed [ZW-1:0] z_next;

  always_comb begin
    dx = d.y >>> step;
    dy = d.x >>> step;
    da = atan_lut(5'(step));
    if (!d.y[CW-1]) begin
      x_next = d.x + dx;
      y_next = d.y - dy;
      z_next = d.z + da;
    end else begin
      x_next = d.x - dx;
      y_next = d.y + dy;
      z_next = d.z - da;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
      q.tag   <= d.tag;
      q.x     <= x_next;
      q.y     <= y_next;
      q.z     <= z_next;
    end
  end

endmodule

/* rtl/point_sector_stride_filter_core.sv */
// ----------------------------------------------------------------------------
// Point sector and stride filter
// Marks each lidar point kept or dropped by stride, finiteness and bearing.
// ----------------------------------------------------------------------------
// Each point runs through an entry cell (stride phase, quadrant pre-rotation),
// a row of CORDIC_STEPS vectoring cells that work out atan2(y,x) in pi/32768
// units, and an output register that makes the keep decision and tracks
// whether the cloud kept anything. A result is offered from the output
// register once its point has passed the entry register and every cell
// register; the cell row advances one place per cycle, so a new point is
// taken every cycle while the result side is ready, and the whole row holds
// while a result waits. Config writes are meant for an idle block.
`include "point_sector_stride_filter_core_macros.svh"

module point_sector_stride_filter_core import psf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  psf_pt_if.sink            pt,
  psf_res_if.source         res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t                    cfg;
  stage_t                  pipe [0:CORDIC_STEPS];
  stage_t                  t;
  logic                    en;
  logic signed [ZW-1:0]    ang;
  logic                    in_win;
  logic                    keep_c;
  logic                    kbase;
  logic                    any_kept;
  logic                    kept_any;
  logic                    res_valid;
  logic                    res_keep;
  logic                    res_last;
  logic                    res_empty;
  logic signed [COORD_BITS-1:0] res_qx;
  logic signed [COORD_BITS-1:0] res_qy;
  logic signed [COORD_BITS-1:0] res_qz;

  assign pready = 1'b1;
  assign en     = !res_valid || res.ready;

  psf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  psf_entry u_entry (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .stride (cfg.stride),
    .pt     (pt),
    .st     (pipe[0])
  );

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    psf_cordic_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .step (SW'(g)),
      .d    (pipe[g]),
      .q    (pipe[g+1])
    );
  end

  assign t = pipe[CORDIC_STEPS];

  always_comb begin
    // the origin has bearing zero
    ang      = t.tag.origin ? '0 : t.z;
    in_win   = !(ang < ZW'(cfg.angle_min) || ang > ZW'(cfg.angle_max));
    keep_c   = t.tag.pass && (!cfg.sector_on || in_win);
    kbase    = t.tag.first ? 1'b0 : kept_any;
    any_kept = kbase || keep_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      kept_any  <= 1'b0;
    end else if (en) begin
      res_valid <= t.valid;
      if (t.valid) begin
        kept_any  <= t.tag.last ? 1'b0 : any_kept;
        res_keep  <= keep_c;
        res_qx    <= t.tag.px;
        res_qy    <= t.tag.py;
        res_qz    <= t.tag.pz;
        res_last  <= t.tag.last;
        res_empty <= t.tag.last && !any_kept;
      end
    end
  end

  assign res.valid        = res_valid;
  assign res.keep         = res_keep;
  assign res.qx           = res_qx;
  assign res.qy           = res_qy;
  assign res.qz           = res_qz;
  assign res.end_of_cloud = res_last;
  assign res.cloud_empty  = res_empty;

  `PSF_ASSERT_NOW(a_kept_not_empty, res.valid && res.end_of_cloud && res.keep,
    !res.cloud_empty, "cloud reported empty although its last item was kept")
  `PSF_ASSERT_NOW(a_empty_only_at_end, res.valid && !res.end_of_cloud,
    !res.cloud_empty, "cloud_empty raised away from the end of a cloud")
  `PSF_ASSERT_NEXT(a_entry_loaded, pt.valid && pt.ready, pipe[0].valid,
    "accepted item did not reach the entry cell")

endmodule
